/* sv/lru_pr_pkg.sv */
// ----------------------------------------------------------------------------
// lru_pr_pkg
// Shared constants and types for the LRU page replacement unit: frame row
// sizing, the word layout and the structs that run along the cell row.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int SLOT_W     = $clog2(MAX_FRAMES);
  localparam int RANK_W     = $clog2(MAX_FRAMES);
  localparam int CFG_W      = 5;
  localparam int FAULT_W    = 32;

  localparam int OUT_USED_W = SLOT_W + PAGE_BITS + FAULT_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;
  localparam int IN_DATA_W  = ((PAGE_BITS + 7) / 8) * 8;

  typedef enum logic {
    OP_REF   = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // Broadcast to every cell: the page under lookup and the active frame count.
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [CFG_W-1:0]     eff;
  } probe_t;

  // Lookup pass, carried from cell 0 upward.
  typedef struct packed {
    logic                  hit_seen;
    logic [RANK_W-1:0]     hit_rank;
    logic                  empty_seen;
    logic [MAX_FRAMES-1:0] rank_or;
  } scan_t;

  // Decision broadcast back to the cells.
  typedef struct packed {
    logic              clear;
    logic              commit;
    logic              found;
    logic              have_empty;
    logic [RANK_W-1:0] max_rank;
    logic [RANK_W-1:0] tgt_rank;
  } cmd_t;

  // Selection pass, carried from cell 0 upward.
  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic [PAGE_BITS-1:0] vic_page;
  } sel_t;

endpackage

/* sv/lru_page_replacement_unit.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// Fully associative page frame store with least-recently-used replacement,
// built as a row of frame cells with a lookup pass and a selection pass.
//
//   channel  dir  handshake               payload
//   in_      in   in_tvalid / in_tready   tuser: opcode; tdata: page_number
//   out_     out  out_tvalid / out_tready tuser: hit, evicted_valid;
//                                         tdata: frame_slot, evicted_page,
//                                         fault_count
//   cfg_     in   cfg_wr_en               cfg_wr_data: frames_in_use
//
// Each word is first registered, then the lookup, selection and rank update
// run across the cell row in ST_EVAL and commit in that same cycle.
// Reset (synchronous): all frames empty, fault count zero, frames_in_use 16.
// A result held by out_tready low holds the update pass; the next word is
// accepted once the pass has committed, while the result may still wait.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lru_pr_pkg::IN_DATA_W-1:0]  in_tdata,   // page_number
  input  logic [0:0]                        in_tuser,   // opcode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lru_pr_pkg::OUT_DATA_W-1:0] out_tdata,  // frame_slot, evicted_page,
                                                        // fault_count, zero pad
  output logic [1:0]                        out_tuser,  // hit, evicted_valid
  input  logic                              cfg_wr_en,
  input  logic [lru_pr_pkg::CFG_W-1:0]      cfg_wr_data // frames_in_use
);
  import lru_pr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  op_t                  op_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [CFG_W-1:0]     frames_r;
  logic [FAULT_W-1:0]   fault_r, fault_nxt;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_ev_r;
  logic [PAGE_BITS-1:0] out_evpage_r;
  logic [FAULT_W-1:0]   out_fault_r;

  logic   accept;
  logic   go;
  logic   evict;
  probe_t probe;
  cmd_t   cmd;
  scan_t  scan_c [MAX_FRAMES+1];
  sel_t   sel_c  [MAX_FRAMES+1];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign go        = (state_r == ST_EVAL) & (~out_valid_r | out_tready);

  always_comb begin
    probe.page = page_r;
    if (frames_r == '0) begin
      probe.eff = CFG_W'(1);
    end else if (frames_r > CFG_W'(MAX_FRAMES)) begin
      probe.eff = CFG_W'(MAX_FRAMES);
    end else begin
      probe.eff = frames_r;
    end
  end

  assign scan_c[0] = '0;
  assign sel_c[0]  = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lru_pr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx_i   (SLOT_W'(g)),
      .probe_i (probe),
      .cmd_i   (cmd),
      .scan_i  (scan_c[g]),
      .scan_o  (scan_c[g+1]),
      .sel_i   (sel_c[g]),
      .sel_o   (sel_c[g+1])
    );
  end

  always_comb begin
    cmd.clear      = go & (op_r == OP_CLEAR);
    cmd.commit     = go & (op_r == OP_REF);
    cmd.found      = scan_c[MAX_FRAMES].hit_seen;
    cmd.have_empty = scan_c[MAX_FRAMES].empty_seen;
    cmd.max_rank   = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (scan_c[MAX_FRAMES].rank_or[i]) begin
        cmd.max_rank = RANK_W'(i);
      end
    end
    cmd.tgt_rank = cmd.found ? scan_c[MAX_FRAMES].hit_rank : cmd.max_rank;
  end

  assign evict     = ~cmd.found & ~cmd.have_empty;
  assign fault_nxt = (fault_r != '1) ? fault_r + FAULT_W'(1) : fault_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EVAL;
      ST_EVAL: if (go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frames_r    <= CFG_W'(MAX_FRAMES);
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        frames_r <= cfg_wr_data;
      end
      if (cmd.clear) begin
        fault_r <= '0;
      end else if (cmd.commit && !cmd.found) begin
        fault_r <= fault_nxt;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_tuser[0]);
      page_r <= in_tdata[PAGE_BITS-1:0];
    end
    if (cmd.clear) begin
      out_hit_r    <= 1'b0;
      out_slot_r   <= '0;
      out_ev_r     <= 1'b0;
      out_evpage_r <= '0;
      out_fault_r  <= '0;
    end else if (cmd.commit) begin
      out_hit_r    <= cmd.found;
      out_slot_r   <= sel_c[MAX_FRAMES].slot;
      out_ev_r     <= evict;
      out_evpage_r <= evict ? sel_c[MAX_FRAMES].vic_page : '0;
      out_fault_r  <= cmd.found ? fault_r : fault_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_ev_r, out_hit_r};
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_fault_r, out_evpage_r, out_slot_r};

endmodule

/* sv/lru_pr_cell.sv */
// ----------------------------------------------------------------------------
// lru_pr_cell
// One page frame: page, valid flag and recency rank. Joins the lookup and
// selection passes of its lower neighbor and applies the broadcast update.
// ----------------------------------------------------------------------------
module lru_pr_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lru_pr_pkg::SLOT_W-1:0] idx_i,
  input  lru_pr_pkg::probe_t            probe_i,
  input  lru_pr_pkg::cmd_t              cmd_i,
  input  lru_pr_pkg::scan_t             scan_i,
  output lru_pr_pkg::scan_t             scan_o,
  input  lru_pr_pkg::sel_t              sel_i,
  output lru_pr_pkg::sel_t              sel_o
);
  import lru_pr_pkg::*;

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic [RANK_W-1:0]    rank_r;

  logic active;
  logic live;
  logic match;
  logic first_hit;
  logic first_empty;
  logic victim;
  logic sel;
  logic age;

  assign active      = {1'b0, idx_i} < probe_i.eff;
  assign live        = valid_r & active;
  assign match       = live & (page_r == probe_i.page);
  assign first_hit   = match & ~scan_i.hit_seen;
  assign first_empty = active & ~valid_r & ~scan_i.empty_seen;
  assign victim      = live & (rank_r == cmd_i.max_rank);

  assign scan_o.hit_seen   = scan_i.hit_seen | match;
  assign scan_o.hit_rank   = first_hit ? rank_r : scan_i.hit_rank;
  assign scan_o.empty_seen = scan_i.empty_seen | (active & ~valid_r);
  assign scan_o.rank_or    = scan_i.rank_or
                           | (live ? (MAX_FRAMES'(1) << rank_r) : '0);

  assign sel = cmd_i.found      ? first_hit   :
               cmd_i.have_empty ? first_empty : victim;

  assign sel_o.slot     = sel_i.slot | (sel ? idx_i : '0);
  assign sel_o.vic_page = sel_i.vic_page | (victim ? page_r : '0);

  // fill ages every resident frame; hit or eviction ages the younger ones
  assign age = valid_r & ((~cmd_i.found & cmd_i.have_empty) | (rank_r < cmd_i.tgt_rank));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (cmd_i.clear) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (cmd_i.commit) begin
      if (sel) begin
        valid_r <= 1'b1;
        rank_r  <= '0;
      end else if (age) begin
        rank_r <= rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit && sel) begin
      page_r <= probe_i.page;
    end
  end

endmodule

/* sv/lru_pr_checker.sv */
// ----------------------------------------------------------------------------
// lru_pr_checker
// Port-level checks for the LRU page replacement unit, bound to the top level.
// ----------------------------------------------------------------------------
module lru_pr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lru_pr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                        out_tuser
);
  import lru_pr_pkg::*;

  localparam int FAULT_LO = SLOT_W + PAGE_BITS;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted during update pass");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("hit reported with an eviction");

  a_evict_faults: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[FAULT_LO +: FAULT_W] != '0)
    else $error("eviction with zero fault count");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind lru_page_replacement_unit lru_pr_checker u_chk (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU page replacement unit. A short directed
// table covers the page extremes, clears, frame counts 0, 2, 16, 17 and
// 31, and hidden frames kept across a count change. Random phases follow,
// each with its own frame count and a page pool a little larger than the
// active frames. Every result word is checked field by field against the
// directed table's expected word or an in-bench LRU predictor.
// ----------------------------------------------------------------------------
module tb;
  import lru_pr_pkg::*;

  localparam int RAND_WORDS = 1880;
  localparam int LONG_HOLD  = 48;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    logic [FAULT_W-1:0]   faults;
  } lookup_t;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    op_t                  op;
    logic [PAGE_BITS-1:0] page;
    logic [CFG_W-1:0]     frames;
    logic                 typed;
    lookup_t              want;
  } plan_row_t;

  localparam plan_row_t PLAN [0:23] = '{
    '{ROW_WORD, OP_REF,   16'h0000, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
    '{ROW_WORD, OP_REF,   16'hFFFF, 5'd0,  1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
    '{ROW_WORD, OP_REF,   16'h0000, 5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
    '{ROW_WORD, OP_REF,   16'h5A5A, 5'd0,  1'b0, '0},
    '{ROW_WORD, OP_CLEAR, 16'hFFFF, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd0}},
    '{ROW_CFG,  OP_REF,   16'h0000, 5'd2,  1'b0, '0},
    '{ROW_WORD, OP_REF,   16'h1111, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
    '{ROW_WORD, OP_REF,   16'h2222, 5'd0,  1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
    '{ROW_WORD, OP_REF,   16'h3333, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b1, 16'h1111, 32'd3}},
    '{ROW_WORD, OP_REF,   16'h2222, 5'd0,  1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd3}},
    '{ROW_WORD, OP_REF,   16'h4444, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b1, 16'h3333, 32'd4}},
    '{ROW_CFG,  OP_REF,   16'h0000, 5'd0,  1'b0, '0},
    '{ROW_WORD, OP_REF,   16'h2222, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b1, 16'h4444, 32'd5}},
    '{ROW_WORD, OP_REF,   16'h2222, 5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd5}},
    '{ROW_CFG,  OP_REF,   16'h0000, 5'd31, 1'b0, '0},
    '{ROW_WORD, OP_REF,   16'h2222, 5'd0,  1'b0, '0},
    '{ROW_WORD, OP_REF,   16'h7777, 5'd0,  1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 32'd6}},
    '{ROW_CFG,  OP_REF,   16'h0000, 5'd17, 1'b0, '0},
    '{ROW_WORD, OP_REF,   16'h4444, 5'd0,  1'b0, '0},
    '{ROW_WORD, OP_REF,   16'h1111, 5'd0,  1'b0, '0},
    '{ROW_CFG,  OP_REF,   16'h0000, 5'd16, 1'b0, '0},
    '{ROW_WORD, OP_REF,   16'hA5A5, 5'd0,  1'b0, '0},
    '{ROW_WORD, OP_CLEAR, 16'h0000, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd0}},
    '{ROW_WORD, OP_REF,   16'h8000, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}}
  };

  localparam logic [CFG_W-1:0] FRAME_SWEEP [0:8] = '{
    5'd1, 5'd16, 5'd4, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd15
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_wr_en;
  logic [CFG_W-1:0]      cfg_wr_data;

  lru_page_replacement_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor state
  logic [PAGE_BITS-1:0] frame_tag   [MAX_FRAMES];
  bit                   frame_held  [MAX_FRAMES];
  int unsigned          frame_age   [MAX_FRAMES];
  logic [FAULT_W-1:0]   fault_tally;
  logic [CFG_W-1:0]     frame_limit;

  lookup_t pending_lookups [$];

  int errors;
  int results_seen;
  int hits_seen;
  int evictions_seen;
  int clears_sent;
  int words_sent;
  int limits_written;
  bit calm;
  bit hold_out;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // make frame f most recent; was_held says whether it held a page
  function automatic void promote_frame(int f, bit was_held);
    int unsigned r0;
    int          k;
    r0 = frame_age[f];
    for (k = 0; k < MAX_FRAMES; k++) begin
      if (k != f && frame_held[k] && (!was_held || frame_age[k] < r0))
        frame_age[k]++;
    end
    frame_age[f]  = 0;
    frame_held[f] = 1'b1;
  endfunction

  function automatic lookup_t lookup_and_replace(op_t op, logic [PAGE_BITS-1:0] page);
    lookup_t r;
    int      m;
    int      j;
    int      slot;
    r = '0;
    if (op == OP_CLEAR) begin
      for (j = 0; j < MAX_FRAMES; j++) begin
        frame_held[j] = 1'b0;
        frame_age[j]  = 0;
      end
      fault_tally = '0;
      return r;
    end
    m = (frame_limit == 0) ? 1 : (frame_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit);
    slot = -1;
    for (j = 0; j < m; j++) begin
      if (slot < 0 && frame_held[j] && frame_tag[j] == page)
        slot = j;
    end
    if (slot >= 0) begin
      r.hit = 1'b1;
      promote_frame(slot, 1'b1);
    end else begin
      for (j = 0; j < m; j++) begin
        if (slot < 0 && !frame_held[j])
          slot = j;
      end
      if (slot >= 0) begin
        promote_frame(slot, 1'b0);
      end else begin
        slot = 0;
        for (j = 1; j < m; j++) begin
          if (frame_age[j] > frame_age[slot])
            slot = j;
        end
        r.ev_valid = 1'b1;
        r.ev_page  = frame_tag[slot];
        promote_frame(slot, 1'b1);
      end
      frame_tag[slot] = page;
      if (fault_tally != '1)
        fault_tally = fault_tally + FAULT_W'(1);
    end
    r.slot   = slot[SLOT_W-1:0];
    r.faults = fault_tally;
    return r;
  endfunction

  task automatic send_word(op_t op, logic [PAGE_BITS-1:0] page, bit typed, lookup_t want);
    lookup_t pred;
    bit      rdy;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= page;
    do begin
      @(negedge clk);
      rdy = in_tready;
      if (rdy) begin
        pred = lookup_and_replace(op, page);
        pending_lookups.push_back(typed ? want : pred);
      end
      @(posedge clk);
    end while (!rdy);
    words_sent++;
    if (op == OP_CLEAR)
      clears_sent++;
  endtask

  task automatic set_frame_limit(logic [CFG_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    frame_limit = v;
    limits_written++;
  endtask

  function automatic void report(string field, logic [FAULT_W-1:0] want, logic [FAULT_W-1:0] got);
    $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, field, want, got);
    errors++;
  endfunction

  // result monitor: inputs only change at posedge, so the negedge view is what the edge sees
  always @(negedge clk) begin
    lookup_t got;
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit      = out_tuser[0];
      got.ev_valid = out_tuser[1];
      got.slot     = out_tdata[SLOT_W-1:0];
      got.ev_page  = out_tdata[SLOT_W +: PAGE_BITS];
      got.faults   = out_tdata[SLOT_W + PAGE_BITS +: FAULT_W];
      results_seen++;
      if (got.hit) hits_seen++;
      if (got.ev_valid) evictions_seen++;
      if (pending_lookups.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %0h", $time, got);
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        if (got.hit !== want.hit)
          report("hit", FAULT_W'(want.hit), FAULT_W'(got.hit));
        if (got.slot !== want.slot)
          report("frame_slot", FAULT_W'(want.slot), FAULT_W'(got.slot));
        if (got.ev_valid !== want.ev_valid)
          report("evicted_valid", FAULT_W'(want.ev_valid), FAULT_W'(got.ev_valid));
        if (got.ev_page !== want.ev_page)
          report("evicted_page", FAULT_W'(want.ev_page), FAULT_W'(got.ev_page));
        if (got.faults !== want.faults)
          report("fault_count", want.faults, got.faults);
      end
    end
  end

  // receiver: random stalls, one long hold on request
  initial begin
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int                   i;
    int                   phase;
    int                   plen;
    int                   n;
    int                   eff;
    int                   psz;
    int                   roll;
    int                   rand_sent;
    int                   guard;
    logic [PAGE_BITS-1:0] base;
    logic [PAGE_BITS-1:0] page;
    logic [CFG_W-1:0]     fc;
    op_t                  op;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_REF;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    calm        = 1'b0;
    hold_out    = 1'b0;
    errors      = 0;
    for (i = 0; i < MAX_FRAMES; i++) begin
      frame_tag[i]  = '0;
      frame_held[i] = 1'b0;
      frame_age[i]  = 0;
    end
    fault_tally = '0;
    frame_limit = CFG_W'(MAX_FRAMES);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].kind == ROW_CFG)
        set_frame_limit(PLAN[i].frames);
      else
        send_word(PLAN[i].op, PLAN[i].page, PLAN[i].typed, PLAN[i].want);
    end

    phase     = 0;
    rand_sent = 0;
    while (rand_sent < RAND_WORDS) begin
      calm = (rand_sent > RAND_WORDS * 85 / 100);
      fc = (phase < $size(FRAME_SWEEP)) ? FRAME_SWEEP[phase] : CFG_W'($urandom_range(0, 31));
      set_frame_limit(fc);
      eff  = (fc == 0) ? 1 : (fc > MAX_FRAMES) ? MAX_FRAMES : int'(fc);
      psz  = eff + $urandom_range(0, 6);
      base = PAGE_BITS'($urandom);
      plen = $urandom_range(60, 140);
      if (phase == 3)
        hold_out = 1'b1;
      for (n = 0; n < plen && rand_sent < RAND_WORDS; n++) begin
        if (phase == 5 && n == plen / 2) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (pending_lookups.size() != 0);
        end
        roll = $urandom_range(0, 99);
        op   = (roll < 2) ? OP_CLEAR : OP_REF;
        page = (roll < 12) ? PAGE_BITS'($urandom)
                           : PAGE_BITS'(base + $urandom_range(0, psz - 1));
        send_word(op, page, 1'b0, '0);
        rand_sent++;
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_lookups.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_lookups.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, pending_lookups.size());
      errors++;
    end
    repeat (8) @(posedge clk);

    $display("Ran %0d words (%0d clears) over %0d frame-count settings in %0d phases.",
             words_sent, clears_sent, limits_written, phase);
    $display("Compared %0d results: %0d hits, %0d evictions, %0d errors.",
             results_seen, hits_seen, evictions_seen, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* lru_page_replacement_unit.f */
sv/lru_pr_pkg.sv
sv/lru_pr_cell.sv
sv/lru_page_replacement_unit.sv
sv/lru_pr_checker.sv
tb/tb.sv
